>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, clocked on rising edge, off while reset is held.
`define SUDF_ASSERT(name, ck, rn, prop, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (prop)) \
        else $error(msg);

// Same, for an antecedent that implies a consequent in the next cycle.
`define SUDF_ASSERT_NEXT(name, ck, rn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/sudf_pkg.sv
`default_nettype none

package sudf_pkg;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_RX    = 2'd2,
        KIND_EOR   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_HEADER = 2'd1,
        ST_CRC    = 2'd2,
        ST_SHORT  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        JOB_WRITE,
        JOB_READ,
        JOB_OUTCOME
    } job_kind_t;

    localparam logic RK_TX   = 1'b0;
    localparam logic RK_READ = 1'b1;

    localparam logic [7:0] SYNC_BYTE   = 8'h05;
    localparam logic [7:0] CRC_POLY    = 8'h07;
    localparam logic [7:0] WRITE_FLAG  = 8'h80;
    localparam logic [7:0] MASTER_ADDR = 8'hFF;

    localparam logic [3:0] ECHO_LEN = 4'd4;
    localparam logic [3:0] FULL_LEN = 4'd12;

    localparam logic [2:0] CRC_BYTE_IDX = 3'd7;
    localparam logic [2:0] WRITE_LAST   = 3'd7;
    localparam logic [2:0] READ_LAST    = 3'd3;
    localparam logic [2:0] OUTCOME_LAST = 3'd0;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef struct packed {
        job_kind_t   kind;
        logic [6:0]  reg_addr;
        logic [31:0] value;
        status_t     status;
    } job_t;

    // one byte of CRC-8, data bits taken LSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        logic [7:0] d;
        c = crc_in;
        d = data;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7] ^ d[0])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
            d = {1'b0, d[7:1]};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> design/sudf_cmd_if.sv
`default_nettype none

interface sudf_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [6:0]  reg_addr;
    logic [31:0] write_value;
    logic [7:0]  rx_byte;

    modport source (output valid, output kind, output reg_addr, output write_value,
                    output rx_byte, input ready);
    modport sink   (input valid, input kind, input reg_addr, input write_value,
                    input rx_byte, output ready);
endinterface

`default_nettype wire

>>> design/sudf_res_if.sv
`default_nettype none

interface sudf_res_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [31:0] reg_data;
    logic [1:0]  read_status;

    modport source (output valid, output result_kind, output tx_byte, output last,
                    output reg_data, output read_status, input ready);
    modport sink   (input valid, input result_kind, input tx_byte, input last,
                    input reg_data, input read_status, output ready);
endinterface

`default_nettype wire

>>> design/sudf_front.sv
`default_nettype none

module sudf_front
    import sudf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    sudf_cmd_if.sink   cmd,
    input  logic       q_full,
    output logic       q_push,
    output job_t       q_data
);

    logic        accept;
    kind_t       kind;
    logic [3:0]  rx_count_reg, rx_count_next;
    logic        pending_reg, pending_next;
    logic [7:0]  crc_reg, crc_next;
    logic [7:0]  reply_reg [8];
    logic        reply_we;
    logic [3:0]  offset;
    logic [2:0]  slot;
    status_t     status;
    logic [31:0] outcome_value;

    assign cmd.ready = !q_full;
    assign accept    = cmd.valid && cmd.ready;
    assign kind      = kind_t'(cmd.kind);
    assign offset    = rx_count_reg - ECHO_LEN;
    assign slot      = offset[2:0];

    always_comb
    begin
        priority if (rx_count_reg < FULL_LEN)
        begin
            status = ST_SHORT;
        end
        else if (reply_reg[0] != SYNC_BYTE || reply_reg[1] != MASTER_ADDR)
        begin
            status = ST_HEADER;
        end
        else if (crc_reg != reply_reg[CRC_BYTE_IDX])
        begin
            status = ST_CRC;
        end
        else
        begin
            status = ST_OK;
        end
    end

    assign outcome_value = (status == ST_OK) ?
        {reply_reg[3], reply_reg[4], reply_reg[5], reply_reg[6]} : 32'd0;

    always_comb
    begin
        rx_count_next   = rx_count_reg;
        pending_next    = pending_reg;
        crc_next        = crc_reg;
        reply_we        = 1'b0;
        q_push          = 1'b0;
        q_data.kind     = JOB_WRITE;
        q_data.reg_addr = cmd.reg_addr;
        q_data.value    = cmd.write_value;
        q_data.status   = ST_OK;
        if (accept)
        begin
            unique case (kind)
                KIND_WRITE:
                begin
                    q_push = 1'b1;
                end
                KIND_READ:
                begin
                    q_push        = 1'b1;
                    q_data.kind   = JOB_READ;
                    rx_count_next = 4'd0;
                    pending_next  = 1'b1;
                end
                KIND_RX:
                begin
                    if (rx_count_reg < ECHO_LEN)
                    begin
                        rx_count_next = rx_count_reg + 4'd1;
                    end
                    else if (rx_count_reg < FULL_LEN)
                    begin
                        reply_we      = 1'b1;
                        rx_count_next = rx_count_reg + 4'd1;
                        if (slot != CRC_BYTE_IDX)
                        begin
                            crc_next = crc8_byte((slot == 3'd0) ? 8'd0 : crc_reg, cmd.rx_byte);
                        end
                    end
                end
                KIND_EOR:
                begin
                    if (pending_reg)
                    begin
                        pending_next  = 1'b0;
                        q_push        = 1'b1;
                        q_data.kind   = JOB_OUTCOME;
                        q_data.value  = outcome_value;
                        q_data.status = status;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_count_reg <= 4'd0;
            pending_reg  <= 1'b0;
        end
        else
        begin
            rx_count_reg <= rx_count_next;
            pending_reg  <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
        if (reply_we)
        begin
            reply_reg[slot] <= cmd.rx_byte;
        end
    end

endmodule

`default_nettype wire

>>> design/sudf_queue.sv
`default_nettype none

module sudf_queue
    import sudf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output job_t pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    job_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full      = (count_reg == DEPTH_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> design/sudf_back.sv
`default_nettype none

module sudf_back
    import sudf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  node_addr,
    input  logic        q_valid,
    input  job_t        q_data,
    output logic        q_pop,
    sudf_res_if.source  res
);

    job_t        job_reg;
    logic        busy_reg, busy_next;
    logic [2:0]  idx_reg, idx_next;
    logic [7:0]  crc_reg;
    logic        out_valid_reg, out_valid_next;
    logic        rk_reg;
    logic [7:0]  tx_reg;
    logic        last_reg;
    logic [31:0] value_reg;
    status_t     status_reg;

    logic        advance;
    logic        emit;
    logic        at_last;
    logic        done;
    logic [2:0]  last_idx;
    logic [7:0]  cur_byte;

    assign advance = !out_valid_reg || res.ready;
    assign emit    = busy_reg && advance;
    assign at_last = (idx_reg == last_idx);
    assign done    = emit && at_last;
    assign q_pop   = q_valid && (!busy_reg || done);

    always_comb
    begin
        unique case (job_reg.kind)
            JOB_WRITE: last_idx = WRITE_LAST;
            JOB_READ:  last_idx = READ_LAST;
            default:   last_idx = OUTCOME_LAST;
        endcase
    end

    always_comb
    begin
        if (job_reg.kind == JOB_WRITE)
        begin
            unique case (idx_reg)
                3'd0:    cur_byte = SYNC_BYTE;
                3'd1:    cur_byte = node_addr;
                3'd2:    cur_byte = WRITE_FLAG | {1'b0, job_reg.reg_addr};
                3'd3:    cur_byte = job_reg.value[31:24];
                3'd4:    cur_byte = job_reg.value[23:16];
                3'd5:    cur_byte = job_reg.value[15:8];
                3'd6:    cur_byte = job_reg.value[7:0];
                default: cur_byte = crc_reg;
            endcase
        end
        else
        begin
            unique case (idx_reg)
                3'd0:    cur_byte = SYNC_BYTE;
                3'd1:    cur_byte = node_addr;
                3'd2:    cur_byte = {1'b0, job_reg.reg_addr};
                default: cur_byte = crc_reg;
            endcase
        end
    end

    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = busy_reg;
        end
        if (q_pop)
        begin
            busy_next = 1'b1;
            idx_next  = 3'd0;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        else if (emit)
        begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_data;
        end
        if (emit)
        begin
            crc_reg <= crc8_byte((idx_reg == 3'd0) ? 8'd0 : crc_reg, cur_byte);
            if (job_reg.kind == JOB_OUTCOME)
            begin
                rk_reg     <= RK_READ;
                tx_reg     <= 8'd0;
                last_reg   <= 1'b0;
                value_reg  <= job_reg.value;
                status_reg <= job_reg.status;
            end
            else
            begin
                rk_reg     <= RK_TX;
                tx_reg     <= cur_byte;
                last_reg   <= at_last;
                value_reg  <= 32'd0;
                status_reg <= ST_OK;
            end
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.result_kind = rk_reg;
    assign res.tx_byte     = tx_reg;
    assign res.last        = last_reg;
    assign res.reg_data    = value_reg;
    assign res.read_status = status_reg;

endmodule

`default_nettype wire

>>> design/stepper_uart_datagram_framer_unit.sv
// Channel   Dir  Beat carries
// cmd       in   kind, reg_addr, write_value, rx_byte
// res       out  result_kind, tx_byte, last, reg_data, read_status
// cfg       in   cfg_we / cfg_data -> node_addr
//
// One beat per cycle on cmd while the job queue has room; one beat per cycle on res
// while res is ready, so a write datagram is 8 beats, a read 4, an outcome 1 (set by
// the back end byte sequencer). Received bytes and ignored end-of-reply beats give
// no result. Each request passes the job queue, job register and output register.
// Reset clears counters, pending flag, queue and output valid; no clearing pass.
// res stalls hold the output register and the back end sequencer; cmd stalls only when the queue is full.
`default_nettype none

module stepper_uart_datagram_framer_unit
    import sudf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_data,
    sudf_cmd_if.sink   cmd,
    sudf_res_if.source res
);

    logic [7:0] node_addr_reg, node_addr_next;
    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_valid;
    job_t       push_job;
    job_t       head_job;

    assign node_addr_next = cfg_we ? cfg_data : node_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_addr_reg <= 8'd0;
        end
        else
        begin
            node_addr_reg <= node_addr_next;
        end
    end

    sudf_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (push_job)
    );

    sudf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (head_job)
    );

    sudf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .node_addr (node_addr_reg),
        .q_valid   (q_valid),
        .q_data    (head_job),
        .q_pop     (q_pop),
        .res       (res)
    );

endmodule

`default_nettype wire

>>> design/sudf_checker.sv
`default_nettype none
`include "assert_macros.svh"

module sudf_checker
    import sudf_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic        res_result_kind,
    input logic [7:0]  res_tx_byte,
    input logic        res_last,
    input logic [31:0] res_reg_data,
    input logic [1:0]  res_read_status
);

    `SUDF_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_tx_byte) && $stable(res_reg_data) && $stable(res_read_status), "res beat changed while stalled")

    `SUDF_ASSERT_NEXT(a_datagram_unbroken, clk, rst_n, res_valid && res_ready && res_result_kind == RK_TX && !res_last, res_valid && res_result_kind == RK_TX, "datagram interrupted")

    `SUDF_ASSERT(a_sync_first, clk, rst_n, (res_valid && res_ready && (res_result_kind == RK_READ || res_last)) ##1 (res_valid && res_result_kind == RK_TX) |-> res_tx_byte == SYNC_BYTE, "datagram does not open with sync")

    `SUDF_ASSERT(a_fail_zero, clk, rst_n, res_valid && res_result_kind == RK_READ && res_read_status != ST_OK |-> res_reg_data == 32'd0, "failed read carries data")

endmodule

bind stepper_uart_datagram_framer_unit sudf_checker u_sudf_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_result_kind (res.result_kind),
    .res_tx_byte     (res.tx_byte),
    .res_last        (res.last),
    .res_reg_data    (res.reg_data),
    .res_read_status (res.read_status)
);

`default_nettype wire
